[hw/rtl/u8dec_pkg.sv]
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and constants shared by the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CpWidth   = 21;
   localparam int unsigned RemWidth  = 2;

   // following bytes still expected
   localparam logic [RemWidth-1:0] RemNone  = 2'd0;
   localparam logic [RemWidth-1:0] RemOne   = 2'd1;
   localparam logic [RemWidth-1:0] RemTwo   = 2'd2;
   localparam logic [RemWidth-1:0] RemThree = 2'd3;

   // one decoded code point
   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               last_point;
      logic               truncated;
   } result_type;

   // decoder state carried from byte to byte
   typedef struct packed {
      logic [RemWidth-1:0] bytes_remaining;
      logic [CpWidth-1:0]  partial_value;
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/u8dec_step.sv]
// ----------------------------------------------------------------------------
// u8dec_step
// Combinational next-state and result logic for one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dec_step (
   input  wire logic                               valid,
   input  wire logic [u8dec_pkg::ByteWidth-1:0]    data_byte,
   input  wire logic                               end_of_string,
   input  wire u8dec_pkg::state_type               state_cur,
   output u8dec_pkg::state_type                    state_nxt,
   output logic                                    result_valid,
   output u8dec_pkg::result_type                   result
);

   logic [u8dec_pkg::CpWidth-1:0] pv;
   logic [u8dec_pkg::CpWidth-1:0] follow_bits;
   logic [5:0]                    low6;

   assign low6 = data_byte[5:0];

   // follower bits placed at their final position
   always_comb begin
      case (state_cur.bytes_remaining)
         u8dec_pkg::RemOne:   follow_bits = {15'd0, low6};
         u8dec_pkg::RemTwo:   follow_bits = {9'd0, low6, 6'd0};
         u8dec_pkg::RemThree: follow_bits = {3'd0, low6, 12'd0};
         default:             follow_bits = '0;
      endcase
   end

   always_comb begin
      state_nxt    = state_cur;
      result_valid = 1'b0;
      result       = '0;
      pv           = '0;
      if (valid) begin
         if (state_cur.bytes_remaining == u8dec_pkg::RemNone) begin
            if (!data_byte[7]) begin
               // plain ASCII gives itself
               result_valid      = 1'b1;
               result.code_point = {13'd0, data_byte};
               result.last_point = end_of_string;
            end else begin
               if (data_byte[7:5] == 3'b110) begin
                  pv = {10'd0, data_byte[4:0], 6'd0};
                  state_nxt.bytes_remaining = u8dec_pkg::RemOne;
               end else if (data_byte[7:4] == 4'b1110) begin
                  pv = {5'd0, data_byte[3:0], 12'd0};
                  state_nxt.bytes_remaining = u8dec_pkg::RemTwo;
               end else begin
                  // four-byte lead, malformed leads included
                  pv = {data_byte[2:0], 18'd0};
                  state_nxt.bytes_remaining = u8dec_pkg::RemThree;
               end
               state_nxt.partial_value = pv;
               if (end_of_string) begin
                  result_valid      = 1'b1;
                  result.code_point = pv;
                  result.last_point = 1'b1;
                  result.truncated  = 1'b1;
                  state_nxt         = '0;
               end
            end
         end else begin
            pv = state_cur.partial_value | follow_bits;
            state_nxt.bytes_remaining = state_cur.bytes_remaining - u8dec_pkg::RemOne;
            state_nxt.partial_value   = pv;
            if (state_cur.bytes_remaining == u8dec_pkg::RemOne) begin
               // sequence complete
               result_valid      = 1'b1;
               result.code_point = pv;
               result.last_point = end_of_string;
               state_nxt         = '0;
            end else if (end_of_string) begin
               result_valid      = 1'b1;
               result.code_point = pv;
               result.last_point = 1'b1;
               result.truncated  = 1'b1;
               state_nxt         = '0;
            end
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/utf8_to_utf32_decoder_core.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_core
// Lax UTF-8 byte stream to 21-bit code point decoder.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one UTF-8 byte per transfer, req_end_of_string on the last byte.
//   rsp_*  : one code point per transfer, with last_point and truncated flags.
//   A byte is decoded in the cycle it is accepted and any result registered;
//   one byte per cycle while req_ready is high. The only loop is the 2-bit
//   remaining count and 21-bit partial value register.
//   Leads and followers produce no result until a sequence completes or the
//   string ends; a string ending mid-sequence gives the partial code point
//   with truncated set.
//   A result register plus one skid register sit on the output, so a new
//   byte is taken while a finished result waits. The skid register fills
//   only when the receiver stalls with the result register already full;
//   req_ready stays low while it is full and returns the cycle after the
//   receiver takes a result.
//   Reset (synchronous, active high) clears the decode state and empties
//   the output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf32_decoder_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [u8dec_pkg::ByteWidth-1:0] req_data_byte,
   input  wire logic                            req_end_of_string,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [u8dec_pkg::CpWidth-1:0]        rsp_code_point,
   output logic                                 rsp_last_point,
   output logic                                 rsp_truncated
);

   u8dec_pkg::state_type  state_ff, state_in;
   u8dec_pkg::result_type step_result;
   u8dec_pkg::result_type out_ff, out_in;
   u8dec_pkg::result_type skid_ff, skid_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic                  req_xfer;
   logic                  step_valid;
   logic                  out_free;

   assign req_ready = !skid_valid_ff;
   assign req_xfer  = req_valid && req_ready;

   // per-byte decode
   u8dec_step u_step (
      .valid         (req_xfer),
      .data_byte     (req_data_byte),
      .end_of_string (req_end_of_string),
      .state_cur     (state_ff),
      .state_nxt     (state_in),
      .result_valid  (step_valid),
      .result        (step_result)
   );

   // output register and skid stage
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_result;
            out_valid_in = step_valid;
         end
      end else if (step_valid) begin
         skid_in       = step_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_ff.code_point;
   assign rsp_last_point = out_ff.last_point;
   assign rsp_truncated  = out_ff.truncated;

   // checks
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_idle_partial_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_remaining == u8dec_pkg::RemNone) |-> (state_ff.partial_value == '0))
      else $error("partial value left over with no sequence open");

   a_trunc_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.truncated) |-> out_ff.last_point)
      else $error("truncated result not marked last");

   a_skid_held: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("skid result dropped while stalled");

endmodule

`default_nettype wire

[verif/utf8_to_utf32_decoder_core_test.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_core_test
// Self-checking bench for the UTF-8 to code point decoder. A short table of
// bytes covers the field extremes, every lead pattern, truncated strings and
// malformed leads. Random strings follow: mostly well-formed multi-byte
// sequences, with some noise bytes, bad leads, loose followers and strings
// that stop mid-sequence. Every result is compared in order against a
// behavioral decoder, under random idle and stall bursts on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf32_decoder_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ByteWidth = u8dec_pkg::ByteWidth;
   localparam int unsigned CpWidth   = u8dec_pkg::CpWidth;
   localparam int unsigned RemWidth  = u8dec_pkg::RemWidth;

   localparam int RandomBytes   = 950;
   localparam int QuietTail     = 150;
   localparam int WatchdogLimit = 2000;

   // shape of one random code point
   typedef enum int {
      KindAscii, KindTwo, KindThree, KindFour, KindNoise, KindBadLead, KindLoose
   } point_kind_type;

   // one row of the directed table; want is used only where typed is set
   typedef struct {
      logic [ByteWidth-1:0]  data;
      logic                  eos;
      bit                    typed;
      u8dec_pkg::result_type want;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [ByteWidth-1:0] req_data_byte;
   logic                 req_end_of_string;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [CpWidth-1:0]   rsp_code_point;
   logic                 rsp_last_point;
   logic                 rsp_truncated;

   // behavioral decoder state
   logic [RemWidth-1:0]  model_rem;
   logic [CpWidth-1:0]   model_acc;

   u8dec_pkg::result_type points_due[$];
   logic [ByteWidth-1:0]  string_bytes[$];

   int  mismatches     = 0;
   int  bytes_sent     = 0;
   int  strings_sent   = 0;
   int  points_checked = 0;
   int  truncations    = 0;
   int  quiet_cycles;
   bit  sender_bursts  = 1'b0;
   bit  receiver_bursts = 1'b0;

   stim_row_type directed_rows [24] = '{
      '{8'h00, 1'b0, 1'b1, {21'h000000, 1'b0, 1'b0}},   // first byte after reset
      '{8'h7F, 1'b1, 1'b1, {21'h00007F, 1'b1, 1'b0}},   // largest single byte
      '{8'hC3, 1'b0, 1'b0, '0},                         // two-byte sequence
      '{8'hA9, 1'b0, 1'b0, '0},
      '{8'hE2, 1'b0, 1'b0, '0},                         // three-byte sequence
      '{8'h82, 1'b0, 1'b0, '0},
      '{8'hAC, 1'b0, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0},                         // four bytes, ends string
      '{8'h9F, 1'b0, 1'b0, '0},
      '{8'h98, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b0, '0},
      '{8'hC3, 1'b1, 1'b1, {21'h0000C0, 1'b1, 1'b1}},   // cut after a lead
      '{8'hE2, 1'b0, 1'b0, '0},                         // cut after one follower
      '{8'h82, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, {21'h1C0000, 1'b1, 1'b1}},   // all-ones lead, cut
      '{8'h80, 1'b0, 1'b0, '0},                         // continuation as lead
      '{8'hFF, 1'b0, 1'b0, '0},                         // followers with bad tops
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hF8, 1'b1, 1'b1, {21'h000000, 1'b1, 1'b1}},   // 11111xxx lead, cut
      '{8'hF7, 1'b0, 1'b0, '0},                         // largest code point
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b1, 1'b0, '0}
   };

   utf8_to_utf32_decoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_point    (rsp_code_point),
      .rsp_last_point    (rsp_last_point),
      .rsp_truncated     (rsp_truncated)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Behavioral decoder: consumes one byte, returns 1 when a code point is out.
   function automatic bit decode_byte(input logic [ByteWidth-1:0] data,
                                      input logic eos,
                                      output u8dec_pkg::result_type point);
      point = '0;
      if (model_rem == u8dec_pkg::RemNone) begin
         if (!data[7]) begin
            point.code_point = CpWidth'(data);
            point.last_point = eos;
            return 1'b1;
         end
         if (data[7:5] == 3'b110) begin
            model_acc = CpWidth'(data[4:0]) << 6;
            model_rem = u8dec_pkg::RemOne;
         end else if (data[7:4] == 4'b1110) begin
            model_acc = CpWidth'(data[3:0]) << 12;
            model_rem = u8dec_pkg::RemTwo;
         end else begin
            // bad leads fall in here too and keep three bits
            model_acc = CpWidth'(data[2:0]) << 18;
            model_rem = u8dec_pkg::RemThree;
         end
      end else begin
         // follower top bits are ignored
         model_acc = model_acc | (CpWidth'(data[5:0]) << (6 * (int'(model_rem) - 1)));
         model_rem = model_rem - 1'b1;
         if (model_rem == u8dec_pkg::RemNone) begin
            point.code_point = model_acc;
            point.last_point = eos;
            model_acc = '0;
            return 1'b1;
         end
      end
      // string ended inside a sequence
      if (eos) begin
         point.code_point = model_acc;
         point.last_point = 1'b1;
         point.truncated  = 1'b1;
         model_acc = '0;
         model_rem = u8dec_pkg::RemNone;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Present one byte, hold until the transfer, then log what it should produce.
   task automatic send_byte(input logic [ByteWidth-1:0] data, input logic eos,
                            input bit typed, input u8dec_pkg::result_type want);
      u8dec_pkg::result_type next_point;
      bit                    fires;
      if (sender_bursts && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_end_of_string <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fires = decode_byte(data, eos, next_point);
      if (typed) begin
         points_due = {points_due, want};
      end else if (fires) begin
         points_due = {points_due, next_point};
      end
      bytes_sent++;
      if (eos) strings_sent++;
      @(negedge clock);
   endtask

   function automatic point_kind_type pick_kind();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 5)       return KindAscii;
      else if (roll < 9)  return KindTwo;
      else if (roll < 13) return KindThree;
      else if (roll < 17) return KindFour;
      else if (roll == 17) return KindNoise;
      else if (roll == 18) return KindBadLead;
      else                return KindLoose;
   endfunction

   // Append one sequence to string_bytes; cut drops at least one follower where the sequence has any.
   task automatic add_point(input point_kind_type kind, input bit cut);
      logic [ByteWidth-1:0] lead;
      int                   follow;
      int                   keep;
      bit                   loose;
      loose  = (kind == KindLoose);
      follow = 0;
      if (kind == KindLoose) kind = point_kind_type'($urandom_range(KindTwo, KindFour));
      case (kind)
         KindAscii: lead = ByteWidth'($urandom_range(0, 8'h7F));
         KindTwo: begin
            lead   = 8'hC0 | ByteWidth'($urandom_range(0, 8'h1F));
            follow = 1;
         end
         KindThree: begin
            lead   = 8'hE0 | ByteWidth'($urandom_range(0, 8'h0F));
            follow = 2;
         end
         KindFour: begin
            lead   = 8'hF0 | ByteWidth'($urandom_range(0, 8'h07));
            follow = 3;
         end
         KindBadLead: begin
            lead   = $urandom_range(0, 1) ? 8'h80 | ByteWidth'($urandom_range(0, 8'h3F))
                                          : 8'hF8 | ByteWidth'($urandom_range(0, 8'h07));
            follow = 3;
         end
         default: lead = ByteWidth'($urandom_range(0, 8'hFF));
      endcase
      keep = (cut && follow > 0) ? $urandom_range(0, follow - 1) : follow;
      string_bytes = {string_bytes, lead};
      for (int i = 0; i < keep; i++) begin
         string_bytes = {string_bytes,
                         loose ? ByteWidth'($urandom_range(0, 8'hFF))
                               : 8'h80 | ByteWidth'($urandom_range(0, 8'h3F))};
      end
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what,
                  want, got);
         mismatches++;
      end
   endtask

   // Receiver: ready with random stall bursts
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (receiver_bursts && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Result checker: every accepted code point against the oldest expectation
   always @(posedge clock) begin
      u8dec_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (points_due.size() == 0) begin
            $display("%0t ns: unexpected code point, expected none, actual 0x%0h",
                     $time, rsp_code_point);
            mismatches++;
         end else begin
            want = points_due.pop_front();
            check_field("code_point", want.code_point, rsp_code_point);
            check_field("last_point", want.last_point, rsp_last_point);
            check_field("truncated", want.truncated, rsp_truncated);
            if (want.truncated) truncations++;
            points_checked++;
         end
      end
   end

   // Watchdog: too long without any transfer on either side
   initial begin : watchdog
      quiet_cycles = 0;
      while (quiet_cycles < WatchdogLimit) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t ns: no transfer for %0d cycles, %0d code points outstanding",
               $time, WatchdogLimit, points_due.size());
      $display("FAILED: results differ");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      int             points;
      bit             cut;
      point_kind_type kind;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      req_end_of_string = 1'b0;
      model_rem         = u8dec_pkg::RemNone;
      model_acc         = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, directed_rows[i].eos, directed_rows[i].typed,
                   directed_rows[i].want);
      end

      // random strings, bursts switched per string, none near the end
      while (bytes_sent < RandomBytes + $size(directed_rows)) begin
         if (bytes_sent < RandomBytes + $size(directed_rows) - QuietTail) begin
            sender_bursts   = ($urandom_range(0, 3) != 0);
            receiver_bursts = ($urandom_range(0, 3) != 0);
         end else begin
            sender_bursts   = 1'b0;
            receiver_bursts = 1'b0;
         end
         string_bytes.delete();
         points = $urandom_range(1, 6);
         for (int p = 0; p < points; p++) begin
            kind = pick_kind();
            cut  = (p == points - 1) && ($urandom_range(0, 5) == 0);
            add_point(kind, cut);
         end
         foreach (string_bytes[i]) begin
            send_byte(string_bytes[i], i == string_bytes.size() - 1, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain, then wait for anything stray
      while (points_due.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Sent %0d bytes in %0d strings; checked %0d code points, %0d truncated.",
               bytes_sent, strings_sent, points_checked, truncations);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hw/rtl/u8dec_pkg.sv
hw/rtl/u8dec_step.sv
hw/rtl/utf8_to_utf32_decoder_core.sv
verif/utf8_to_utf32_decoder_core_test.sv
